FILE: rtl/core/tpes_pkg.sv
// Package for the typed priority event stacks.
// Holds item and result structs, operation and status codes, and the
// stage-1 status struct shared by the control and top-level modules.
package tpes_pkg;

	localparam int CLASS_COUNT       = 8;
	localparam int CLASS_WIDTH       = 3;
	localparam int PAYLOAD_WIDTH     = 32;
	localparam int DEPTH_DEFAULT     = 256;
	localparam int HANDLE_W_DEFAULT  = 32;

	// operation codes
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	// one input item
	typedef struct packed {
		logic                     operation;
		logic [CLASS_WIDTH-1:0]   event_class;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} item_t;

	// one result item
	typedef struct packed {
		logic [PAYLOAD_WIDTH-1:0] out_payload;
		logic [CLASS_WIDTH-1:0]   out_class;
		logic [1:0]               status;
		logic                     all_empty;
	} result_t;

	// memory access strobes from control to the stack memory
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

	// stage-1 outcome of one item, waiting on the memory read data
	typedef struct packed {
		logic                   pop_ok;
		logic [CLASS_WIDTH-1:0] cls;
		status_t                status;
		logic                   all_empty;
	} slot_t;

endpackage

FILE: rtl/core/typed_priority_event_stacks.sv
// Top level of the typed priority event stacks.
// Depends on tpes_pkg, tpes_fill_ctrl and tpes_stack_mem.
//
// Usage:
//   Eight LIFO stacks, one per event class; class 0 pops first.
//   Command channel: an item transfers on a rising edge with start high
//   and busy low. busy stays low, so one item may transfer every cycle.
//   operation 0 pushes payload on the stack of event_class; operation 1
//   pops the top of the lowest-numbered non-empty stack.
//   Result channel: exactly one result per item, shown for one cycle with
//   done high, in the cycle right after the item transferred.
//   The receiver cannot stall; results must be taken as they appear.
//   Throughput: one item per cycle. Pushes write the stack memory at the
//   transfer edge; pops read it at that edge and the registered read data
//   forms the result the next cycle. Fill counts live in flip-flops, so a
//   following item always sees the updated counts.
//   A push to a full stack is dropped with status overflow; a pop with all
//   stacks empty returns status underflow. Both give payload and class 0.
//   Reset clears all fill counts at once; the memory needs no clearing
//   because an entry is only read after it was pushed.
module typed_priority_event_stacks
	import tpes_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEFAULT,
	parameter int HANDLE_WIDTH = HANDLE_W_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	localparam int WORDS  = CLASS_COUNT * DEPTH;
	localparam int ADDR_W = $clog2(WORDS);

	mem_ctl_t              ctl;
	logic [ADDR_W-1:0]     addr;
	logic [HANDLE_WIDTH-1:0] wdata;
	logic [HANDLE_WIDTH-1:0] rdata;
	logic                  valid_s1;
	slot_t                 slot_s1;
	logic                  fire;

	assign busy = 1'b0;
	assign fire = start && !busy;

	tpes_fill_ctrl #(
		.DEPTH    (DEPTH),
		.HANDLE_W (HANDLE_WIDTH),
		.ADDR_W   (ADDR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item),
		.ctl      (ctl),
		.addr     (addr),
		.wdata    (wdata),
		.valid_s1 (valid_s1),
		.slot_s1  (slot_s1)
	);

	tpes_stack_mem #(
		.ADDR_W   (ADDR_W),
		.HANDLE_W (HANDLE_WIDTH),
		.WORDS    (WORDS)
	) u_mem (
		.clk   (clk),
		.ctl   (ctl),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// result assembly from the stage-1 slot and the read data
	assign done               = valid_s1;
	assign result.out_payload = slot_s1.pop_ok ? PAYLOAD_WIDTH'(rdata) : '0;
	assign result.out_class   = slot_s1.cls;
	assign result.status      = slot_s1.status;
	assign result.all_empty   = slot_s1.all_empty;

endmodule

FILE: rtl/core/tpes_stack_mem.sv
// Single-port synchronous memory holding all eight stacks back to back.
// Depends on tpes_pkg for the access strobe struct.
module tpes_stack_mem
	import tpes_pkg::*;
#(
	parameter int ADDR_W   = 11,
	parameter int HANDLE_W = HANDLE_W_DEFAULT,
	parameter int WORDS    = 2048
) (
	input  logic                clk,
	input  mem_ctl_t            ctl,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [HANDLE_W-1:0] wdata,
	output logic [HANDLE_W-1:0] rdata
);

	logic [HANDLE_W-1:0] mem [WORDS];
	logic [HANDLE_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tpes_fill_ctrl.sv
// Fill counters, priority pick and memory address generation.
// Depends on tpes_pkg; drives tpes_stack_mem and the stage-1 result slot.
module tpes_fill_ctrl
	import tpes_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEFAULT,
	parameter int HANDLE_W = HANDLE_W_DEFAULT,
	parameter int ADDR_W   = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  item_t               item,
	output mem_ctl_t            ctl,
	output logic [ADDR_W-1:0]   addr,
	output logic [HANDLE_W-1:0] wdata,
	output logic                valid_s1,
	output slot_t               slot_s1
);

	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [FILL_W-1:0]      fill_q    [CLASS_COUNT];
	logic [FILL_W-1:0]      fill_next [CLASS_COUNT];
	logic                   pick_found;
	logic [CLASS_WIDTH-1:0] pick_cls;
	logic                   is_pop;
	logic                   push_full;
	logic                   do_push;
	logic                   do_pop;
	logic [CLASS_WIDTH-1:0] sel_cls;
	logic [FILL_W-1:0]      sel_idx;
	logic                   empty_next;
	logic                   fills_in_range;
	status_t                status_c;

	// lowest-numbered non-empty class wins
	always_comb begin
		pick_found = 1'b0;
		pick_cls   = '0;
		for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
			if (fill_q[c] != '0) begin
				pick_found = 1'b1;
				pick_cls   = CLASS_WIDTH'(c);
			end
		end
	end

	assign is_pop    = (item.operation == OP_POP);
	assign push_full = (fill_q[item.event_class] == FILL_W'(DEPTH));
	assign do_push   = fire && !is_pop && !push_full;
	assign do_pop    = fire && is_pop && pick_found;

	// next fill counts and emptiness after this transfer
	always_comb begin
		for (int c = 0; c < CLASS_COUNT; c++) begin
			fill_next[c] = fill_q[c];
		end
		if (do_push) begin
			fill_next[item.event_class] = fill_q[item.event_class] + FILL_W'(1);
		end
		if (do_pop) begin
			fill_next[pick_cls] = fill_q[pick_cls] - FILL_W'(1);
		end
		empty_next = 1'b1;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			if (fill_next[c] != '0) begin
				empty_next = 1'b0;
			end
		end
	end

	// memory address: class base plus index within the stack
	assign sel_cls = is_pop ? pick_cls : item.event_class;
	assign sel_idx = is_pop ? (fill_q[pick_cls] - FILL_W'(1)) : fill_q[item.event_class];
	assign addr    = ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(DEPTH)) + ADDR_W'(sel_idx);
	assign wdata   = HANDLE_W'(item.payload);
	assign ctl.we  = do_push;
	assign ctl.re  = do_pop;

	always_comb begin
		status_c = STAT_OK;
		if (fire && !is_pop && push_full) begin
			status_c = STAT_OVERFLOW;
		end else if (fire && is_pop && !pick_found) begin
			status_c = STAT_UNDERFLOW;
		end
	end

	// fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				fill_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				fill_q[c] <= fill_next[c];
			end
		end
	end

	// stage-1 strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= fire;
		end
	end

	// stage-1 outcome, all but the payload, which comes from the read data
	always_ff @(posedge clk) begin
		if (fire) begin
			slot_s1.pop_ok    <= do_pop;
			slot_s1.cls       <= do_pop ? pick_cls : '0;
			slot_s1.status    <= status_c;
			slot_s1.all_empty <= empty_next;
		end
	end

	always_comb begin
		fills_in_range = 1'b1;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			if (fill_q[c] > FILL_W'(DEPTH)) begin
				fills_in_range = 1'b0;
			end
		end
	end

	// no counter ever passes the stack depth
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fills_in_range)
		else $error("stack fill count beyond depth");

	// an underflow can only be reported with every stack empty
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && slot_s1.status == STAT_UNDERFLOW |-> slot_s1.all_empty)
		else $error("underflow reported with a non-empty stack");

	// a stored push leaves at least one stack non-empty
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> valid_s1 && !slot_s1.all_empty && slot_s1.status == STAT_OK)
		else $error("push stored but all_empty reported");

	// memory never written and read in the same cycle
	a_mem_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.we, ctl.re}))
		else $error("stack memory write and read together");

endmodule
